// ===== sv/rld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, reset constant, matrix helpers and pair index helpers for the diffusion layer.
// ----------------------------------------------------------------------------
package rld_pkg;

	localparam logic [63:0] BASE_MATRIX_RESET = 64'hC873_F514_01C0_DE82;

	// row 0 sits in the top byte, row bit 7 is column 0
	typedef logic [0:7][7:0] mat_t;
	typedef mat_t [0:3] mat_set_t;
	// byte 0 sits in the top byte
	typedef logic [0:15][7:0] state_t;

	typedef struct packed {
		state_t     state;
		logic [1:0] rnd;
		logic       inv;
	} item_t;

	function automatic logic [7:0] mat_apply(input mat_t m, input logic [7:0] v);
		logic [7:0] y;
		y = '0;
		for (int i = 0; i < 8; i++) begin
			y[7 - i] = ^(m[i] & v);
		end
		return y;
	endfunction

	// clockwise quarter turn: new[r][c] = old[7-c][r]
	function automatic mat_t mat_rotate(input mat_t src);
		mat_t dst;
		dst = '0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				dst[r][7 - c] = src[7 - c][7 - r];
			end
		end
		return dst;
	endfunction

	// byte index of the lower partner of pair p in stage st
	function automatic logic [3:0] pair_left(input logic [1:0] st, input logic [2:0] p);
		logic [3:0] idx;
		case (st)
			2'd0: idx = {p, 1'b0};
			2'd1: idx = {p[2:1], 1'b0, p[0]};
			2'd2: idx = {p[2], 1'b0, p[1:0]};
			default: idx = {1'b0, p};
		endcase
		return idx;
	endfunction

	// pair that byte j belongs to in stage st
	function automatic logic [2:0] pair_of(input logic [1:0] st, input logic [3:0] j);
		logic [2:0] p;
		case (st)
			2'd0: p = j[3:1];
			2'd1: p = {j[3:2], j[0]};
			2'd2: p = {j[3], j[1:0]};
			default: p = j[2:0];
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== sv/rld_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rld_cell
// One byte-pair cell: three chained matrix-xor steps on the pair.
// ----------------------------------------------------------------------------
module rld_cell (
	input  wire rld_pkg::mat_t ma,
	input  wire rld_pkg::mat_t mb,
	input  wire logic [7:0]    l_in,
	input  wire logic [7:0]    r_in,
	output logic [7:0]         l_out,
	output logic [7:0]         r_out
);

	logic [7:0] l_mid;

	always_comb begin
		l_mid = l_in ^ rld_pkg::mat_apply(ma, r_in);
		r_out = r_in ^ rld_pkg::mat_apply(mb, l_mid);
		l_out = l_mid ^ rld_pkg::mat_apply(ma, r_out);
	end

endmodule
`default_nettype wire

// ===== sv/rld_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rld_stage
// One diffusion stage: eight cells side by side, then bytes merged back.
// ----------------------------------------------------------------------------
module rld_stage (
	input  wire logic [1:0]        stage_idx,
	input  wire rld_pkg::mat_set_t mats,
	input  wire rld_pkg::item_t    item,
	output rld_pkg::state_t        state_out
);

	logic [7:0][7:0] l_in;
	logic [7:0][7:0] r_in;
	logic [7:0][7:0] l_res;
	logic [7:0][7:0] r_res;
	logic [3:0]      mask;

	assign mask = 4'(1) << stage_idx;

	for (genvar p = 0; p < 8; p++) begin : g_lane
		logic [3:0] li;
		logic [1:0] k;

		assign li      = rld_pkg::pair_left(stage_idx, 3'(p));
		assign k       = item.rnd + stage_idx + 2'(p);
		assign l_in[p] = item.state[li];
		assign r_in[p] = item.state[li | mask];

		rld_cell u_cell (
			.ma    (mats[k]),
			.mb    (mats[k ^ 2'd1]),
			.l_in  (l_in[p]),
			.r_in  (r_in[p]),
			.l_out (l_res[p]),
			.r_out (r_res[p])
		);
	end

	// put each lane's bytes back at their state positions
	always_comb begin
		for (int j = 0; j < 16; j++) begin
			if ((4'(j) & mask) != 4'd0) begin
				state_out[j] = r_res[rld_pkg::pair_of(stage_idx, 4'(j))];
			end else begin
				state_out[j] = l_res[rld_pkg::pair_of(stage_idx, 4'(j))];
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/rotor_linear_diffusion_layer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotor_linear_diffusion_layer
// Linear diffusion layer on a 128-bit state, four pipelined stages.
// ----------------------------------------------------------------------------
// Takes one word per clock while item_stall is low and passes each word
// through four registered stages, each eight byte-pair cells wide with
// three chained 8x8 matrix products per cell, to the result registers.
// Stalls ripple back only through full stages, so empty slots are filled
// even while a result waits. The inverse runs the same stages in reverse
// order. The base matrix is loaded through the config channel, which is
// always ready, and must only be changed while idle.
module rotor_linear_diffusion_layer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] base_matrix,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [63:0] state_high,
	input  wire logic [63:0] state_low,
	input  wire logic [1:0]  round_offset,
	input  wire logic        inverse,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low
);

	logic [63:0]       base_q;
	rld_pkg::mat_set_t mats;

	rld_pkg::item_t item_s0, item_s1, item_s2, item_s3, item_s4;
	logic           valid_s1, valid_s2, valid_s3, valid_s4;
	logic           load_s1, load_s2, load_s3, load_s4;
	rld_pkg::state_t st_s0, st_s1, st_s2, st_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= rld_pkg::BASE_MATRIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_matrix;
		end
	end

	// rotations are pure wiring
	assign mats[0] = base_q;
	assign mats[1] = rld_pkg::mat_rotate(mats[0]);
	assign mats[2] = rld_pkg::mat_rotate(mats[1]);
	assign mats[3] = rld_pkg::mat_rotate(mats[2]);

	assign item_s0.state = {state_high, state_low};
	assign item_s0.rnd   = round_offset;
	assign item_s0.inv   = inverse;

	// a stage loads when empty or when its word moves on
	assign load_s4    = !valid_s4 || !result_stall;
	assign load_s3    = !valid_s3 || load_s4;
	assign load_s2    = !valid_s2 || load_s3;
	assign load_s1    = !valid_s1 || load_s2;
	assign item_stall = !load_s1;

	rld_stage u_stage0 (
		.stage_idx (item_s0.inv ? 2'd3 : 2'd0),
		.mats      (mats),
		.item      (item_s0),
		.state_out (st_s0)
	);

	rld_stage u_stage1 (
		.stage_idx (item_s1.inv ? 2'd2 : 2'd1),
		.mats      (mats),
		.item      (item_s1),
		.state_out (st_s1)
	);

	rld_stage u_stage2 (
		.stage_idx (item_s2.inv ? 2'd1 : 2'd2),
		.mats      (mats),
		.item      (item_s2),
		.state_out (st_s2)
	);

	rld_stage u_stage3 (
		.stage_idx (item_s3.inv ? 2'd0 : 2'd3),
		.mats      (mats),
		.item      (item_s3),
		.state_out (st_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= item_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
			if (load_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			item_s1 <= '{state: st_s0, rnd: item_s0.rnd, inv: item_s0.inv};
		end
		if (load_s2 && valid_s1) begin
			item_s2 <= '{state: st_s1, rnd: item_s1.rnd, inv: item_s1.inv};
		end
		if (load_s3 && valid_s2) begin
			item_s3 <= '{state: st_s2, rnd: item_s2.rnd, inv: item_s2.inv};
		end
		if (load_s4 && valid_s3) begin
			item_s4 <= '{state: st_s3, rnd: item_s3.rnd, inv: item_s3.inv};
		end
	end

	assign result_valid = valid_s4;
	assign result_high  = item_s4.state[0:7];
	assign result_low   = item_s4.state[8:15];

	// an accepted word always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> valid_s1)
		else $error("accepted word did not reach first stage");

	// an empty first stage never pushes back on the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("input stalled with empty first stage");

	// bubbles collapse: a word in front of an empty slot moves forward
	a_bubble_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !valid_s3) |=> valid_s3)
		else $error("word stuck behind empty stage three");

	a_bubble_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !valid_s4) |=> valid_s4)
		else $error("word stuck behind empty output stage");

endmodule
`default_nettype wire

// ===== bench/rotor_linear_diffusion_layer_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotor_linear_diffusion_layer_tb
// Self-checking bench for the linear diffusion layer.
// ----------------------------------------------------------------------------
// Each accepted input word is run through a behavioral copy of the 96-step
// layer and the predicted state is queued. Result words are compared in order.
// Phases cover the reset matrix, corner-case matrices and random matrices.
// Some random words are a result fed back with a random direction.
// Both sides of the handshake are throttled at varying rates.
module rotor_linear_diffusion_layer_tb;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] base_matrix;
	logic        item_valid;
	logic        item_stall;
	logic [63:0] state_high;
	logic [63:0] state_low;
	logic [1:0]  round_offset;
	logic        inverse;
	logic        result_valid;
	logic        result_stall;
	logic [63:0] result_high;
	logic [63:0] result_low;

	logic [63:0]  layer_matrix;
	logic [127:0] diffused_q[$];
	logic [127:0] last_diffused;
	int           sender_idle_pct;
	int           receiver_idle_pct;
	int           mismatch_count;
	int           cycle_count;

	rotor_linear_diffusion_layer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.base_matrix  (base_matrix),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.state_high   (state_high),
		.state_low    (state_low),
		.round_offset (round_offset),
		.inverse      (inverse),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_high  (result_high),
		.result_low   (result_low)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// behavioral layer: four stages of eight cells, three matrix steps per cell
	function automatic logic [127:0] diffuse_state(input logic [127:0] s,
			input logic [1:0] rnd, input logic inv, input logic [63:0] mtx);
		logic [7:0]   rows [0:3][0:7];
		logic [7:0]   x [0:15];
		logic [3:0]   to_byte [0:95];
		logic [3:0]   from_byte [0:95];
		logic [1:0]   which [0:95];
		logic [1:0]   k;
		logic [7:0]   v;
		logic [7:0]   y;
		logic [127:0] out;
		int           n;
		int           idx;
		int           pair;
		n = 0;
		for (int r = 0; r < 8; r++) begin
			rows[0][r] = mtx[63 - 8 * r -: 8];
		end
		// each quarter turn: new row r, column c comes from old row 7-c, column r
		for (int m = 1; m < 4; m++) begin
			for (int r = 0; r < 8; r++) begin
				for (int c = 0; c < 8; c++) begin
					rows[m][r][7 - c] = rows[m - 1][7 - c][7 - r];
				end
			end
		end
		for (int b = 0; b < 16; b++) begin
			x[b] = s[127 - 8 * b -: 8];
		end
		for (int st = 0; st < 4; st++) begin
			pair = 0;
			for (int b = 0; b < 16; b++) begin
				if (b < (b ^ (1 << st))) begin
					k = rnd + st[1:0] + pair[1:0];
					to_byte[n] = 4'(b);
					from_byte[n] = 4'(b ^ (1 << st));
					which[n] = k;
					to_byte[n + 1] = 4'(b ^ (1 << st));
					from_byte[n + 1] = 4'(b);
					which[n + 1] = k ^ 2'd1;
					to_byte[n + 2] = 4'(b);
					from_byte[n + 2] = 4'(b ^ (1 << st));
					which[n + 2] = k;
					n += 3;
					pair++;
				end
			end
		end
		for (int i = 0; i < 96; i++) begin
			idx = inv ? 95 - i : i;
			v = x[from_byte[idx]];
			y = '0;
			for (int r = 0; r < 8; r++) begin
				y[7 - r] = ^(rows[which[idx]][r] & v);
			end
			x[to_byte[idx]] ^= y;
		end
		for (int b = 0; b < 16; b++) begin
			out[127 - 8 * b -: 8] = x[b];
		end
		return out;
	endfunction

	// result side: check every accepted word, then pick the next stall
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (diffused_q.size() == 0) begin
				$display("%0t: unexpected result word %h_%h", $time, result_high, result_low);
				mismatch_count++;
			end else begin
				want = diffused_q.pop_front();
				if (result_high !== want[127:64]) begin
					$display("%0t: result_high expected %h actual %h", $time,
						want[127:64], result_high);
					mismatch_count++;
				end
				if (result_low !== want[63:0]) begin
					$display("%0t: result_low expected %h actual %h", $time,
						want[63:0], result_low);
					mismatch_count++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
			input logic [1:0] rnd, input logic inv);
		logic [127:0] predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		state_high   <= hi;
		state_low    <= lo;
		round_offset <= rnd;
		inverse      <= inv;
		do @(posedge clk); while (item_stall);
		predicted = diffuse_state({hi, lo}, rnd, inv, layer_matrix);
		diffused_q.insert(diffused_q.size(), predicted);
		last_diffused = predicted;
	endtask

	// block is idle once every expected word is back
	task automatic drain;
		item_valid <= 1'b0;
		while (diffused_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_matrix(input logic [63:0] value);
		drain();
		cfg_valid   <= 1'b1;
		base_matrix <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		layer_matrix = value;
	endtask

	task automatic test_reset_matrix;
		send_word('0, '0, 2'd0, 1'b0);
		send_word('1, '1, 2'd0, 1'b0);
		send_word('1, '1, 2'd1, 1'b1);
		send_word(64'h0100_0000_0000_0000, '0, 2'd1, 1'b0);
		send_word(64'h0100_0000_0000_0000, '0, 2'd2, 1'b1);
		send_word('0, 64'h0000_0000_0000_0080, 2'd3, 1'b0);
		send_word('0, 64'h0000_0000_0000_0080, 2'd3, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 2'd2, 1'b0);
		send_word(64'h8000_0000_0000_0000, 64'h1, 2'd0, 1'b1);
		send_word(last_diffused[127:64], last_diffused[63:0], 2'd0, 1'b0);
	endtask

	task automatic test_corner_matrices;
		// zero matrix leaves the state untouched
		write_matrix('0);
		send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 2'd1, 1'b0);
		send_word('1, '0, 2'd2, 1'b1);
		// all ones is singular
		write_matrix('1);
		send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 2'd3, 1'b0);
		send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 2'd3, 1'b1);
		send_word('0, 64'h1, 2'd0, 1'b0);
		// identity, and its rotations
		write_matrix(64'h8040_2010_0804_0201);
		send_word(64'hDEAD_BEEF_0000_FFFF, 64'h1234_5678_9ABC_DEF0, 2'd0, 1'b0);
		send_word(last_diffused[127:64], last_diffused[63:0], 2'd0, 1'b1);
		send_word('1, '1, 2'd1, 1'b0);
	endtask

	task automatic test_random_words(input int count);
		logic [63:0] hi;
		logic [63:0] lo;
		logic [1:0]  rnd;
		logic        inv;
		int          kind;
		int          pos;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9);
			rnd  = 2'($urandom_range(3));
			inv  = 1'($urandom_range(1));
			hi   = {$urandom, $urandom};
			lo   = {$urandom, $urandom};
			if (kind == 0) begin
				// one hot state
				pos = $urandom_range(127);
				{hi, lo} = 128'h1 << pos;
			end else if (kind == 1) begin
				// feed a result back through a random direction
				{hi, lo} = last_diffused;
				inv = 1'($urandom_range(1));
			end
			send_word(hi, lo, rnd, inv);
		end
	endtask

	task automatic test_throttle_phases;
		sender_idle_pct   = 37;
		receiver_idle_pct = 52;
		write_matrix({$urandom, $urandom});
		test_random_words(400);
		sender_idle_pct   = 52;
		receiver_idle_pct = 37;
		write_matrix({$urandom, $urandom});
		test_random_words(400);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		write_matrix(rld_pkg::BASE_MATRIX_RESET);
		test_random_words(400);
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		base_matrix       <= '0;
		item_valid        <= 1'b0;
		state_high        <= '0;
		state_low         <= '0;
		round_offset      <= '0;
		inverse           <= 1'b0;
		result_stall      <= 1'b0;
		cycle_count       = 0;
		mismatch_count    = 0;
		last_diffused     = '0;
		layer_matrix      = rld_pkg::BASE_MATRIX_RESET;
		sender_idle_pct   = 37;
		receiver_idle_pct = 52;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_matrix();
		test_corner_matrices();
		test_throttle_phases();

		drain();
		// catch any stray words after the last one
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && diffused_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/rld_pkg.sv
sv/rld_cell.sv
sv/rld_stage.sv
sv/rotor_linear_diffusion_layer.sv
bench/rotor_linear_diffusion_layer_tb.sv
